// ===== rtl/two_level_interval_offset_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// Two-level interval offset table: assertion macros
// Short forms for the concurrent assertions of the port checker.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_INTERVAL_OFFSET_TABLE_TOP_DEFINES_SVH
`define TWO_LEVEL_INTERVAL_OFFSET_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TLOT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define TLOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tlot_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-level interval offset table: package
// Sizes, request and result types, status codes and the height store address.
// ----------------------------------------------------------------------------
package tlot_pkg;

   localparam int DIST_ENTRIES   = 8;
   localparam int HEIGHT_ENTRIES = 8;

   localparam int DIDX_W       = (DIST_ENTRIES > 1) ? $clog2(DIST_ENTRIES) : 1;
   localparam int HCNT_W       = $clog2(HEIGHT_ENTRIES + 1);
   localparam int HSTORE_DEPTH = DIST_ENTRIES * HEIGHT_ENTRIES;
   localparam int HADDR_W      = (HSTORE_DEPTH > 1) ? $clog2(HSTORE_DEPTH) : 1;
   localparam int CMP_W        = 17;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_STORED  = 2'd0,
      ST_OVERLAP = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef struct packed {
      logic               mode;
      logic [15:0]        dist_low;
      logic [15:0]        dist_high;
      logic signed [15:0] height_low;
      logic signed [15:0] height_high;
      logic signed [15:0] pitch_in;
      logic signed [15:0] yaw_in;
      logic [15:0]        query_dist;
      logic signed [15:0] query_height;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               found;
      logic signed [15:0] pitch_out;
      logic signed [15:0] yaw_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0] lo;
      logic [15:0] hi;
   } dist_entry_type;

   typedef struct packed {
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
   } height_entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [HADDR_W-1:0] wr_addr;
      height_entry_type wr_data;
      logic [HADDR_W-1:0] rd_addr;
   } hstore_ctl_type;

   function automatic logic [HADDR_W-1:0] height_addr(logic [DIDX_W-1:0] d,
                                                      logic [HCNT_W-1:0] j);
      int sum;
      sum = int'(d) * HEIGHT_ENTRIES + int'(j);
      return HADDR_W'(sum);
   endfunction

endpackage

// ===== rtl/two_level_interval_offset_table_top.sv =====
// ----------------------------------------------------------------------------
// Two-level interval offset table
// Calibration table of distance bands, each holding a list of height bands
// with pitch and yaw offsets; takes inserts and point lookups.
// ----------------------------------------------------------------------------
//
//   Channel    Ports                       Handshake
//   request    start, busy, req_item       taken when start is high, busy low
//   result     rsp_strobe, rsp_item        valid for one cycle, never stalled
//
// A request scans the distance entries in turn, then takes each height entry
// of the matching band through a read state and a compare state, since the
// height store read is registered. The result appears in the cycle after busy
// falls' edge, and a new request may be taken in that same cycle.
// Synchronous reset empties the table; no clearing pass is needed.
// The result side cannot stall the block.
//
module two_level_interval_offset_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tlot_pkg::req_type req_item,
   output logic              rsp_strobe,
   output tlot_pkg::rsp_type rsp_item
);
   import tlot_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_DSCAN = 4'b0010,
      S_HREAD = 4'b0100,
      S_HCMP  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [DIDX_W-1:0] didx_ff, didx_in;
   logic [HCNT_W-1:0] hidx_ff, hidx_in;
   logic [HCNT_W-1:0] hcnt_ff, hcnt_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              dist_valid_ff [DIST_ENTRIES];
   logic              dist_valid_in [DIST_ENTRIES];
   dist_entry_type    dist_bounds_ff [DIST_ENTRIES];
   dist_entry_type    dist_bounds_in [DIST_ENTRIES];
   logic [HCNT_W-1:0] height_count_ff [DIST_ENTRIES];
   logic [HCNT_W-1:0] height_count_in [DIST_ENTRIES];

   hstore_ctl_type    hs_ctl;
   height_entry_type  hs_rd_data;

   logic signed [CMP_W-1:0] cmp_a_lo, cmp_a_hi, cmp_b_lo, cmp_b_hi;
   logic                    cmp_hit;
   dist_entry_type          cur_bounds;
   rsp_type                 result;
   logic                    finish;

   tlot_cmp u_cmp (
      .a_lo    (cmp_a_lo),
      .a_hi    (cmp_a_hi),
      .b_lo    (cmp_b_lo),
      .b_hi    (cmp_b_hi),
      .overlap (cmp_hit)
   );

   tlot_hstore u_hstore (
      .clock   (clock),
      .ctl     (hs_ctl),
      .rd_data (hs_rd_data)
   );

   assign cur_bounds = dist_bounds_ff[didx_ff];

   always_comb begin
      if (state_ff == S_HCMP) begin
         cmp_a_lo = CMP_W'(hs_rd_data.lo);
         cmp_a_hi = CMP_W'(hs_rd_data.hi);
      end else begin
         cmp_a_lo = CMP_W'({1'b0, cur_bounds.lo});
         cmp_a_hi = CMP_W'({1'b0, cur_bounds.hi});
      end
      unique case ({state_ff == S_HCMP, req_ff.mode})
         {1'b0, MODE_INSERT}: begin
            cmp_b_lo = CMP_W'({1'b0, req_ff.dist_low});
            cmp_b_hi = CMP_W'({1'b0, req_ff.dist_high});
         end
         {1'b0, MODE_LOOKUP}: begin
            cmp_b_lo = CMP_W'({1'b0, req_ff.query_dist});
            cmp_b_hi = CMP_W'({1'b0, req_ff.query_dist});
         end
         {1'b1, MODE_INSERT}: begin
            cmp_b_lo = CMP_W'(req_ff.height_low);
            cmp_b_hi = CMP_W'(req_ff.height_high);
         end
         default: begin
            cmp_b_lo = CMP_W'(req_ff.query_height);
            cmp_b_hi = CMP_W'(req_ff.query_height);
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      didx_in         = didx_ff;
      hidx_in         = hidx_ff;
      hcnt_in         = hcnt_ff;
      dist_valid_in   = dist_valid_ff;
      dist_bounds_in  = dist_bounds_ff;
      height_count_in = height_count_ff;
      finish          = 1'b0;
      result          = '{status: ST_STORED, found: 1'b0, pitch_out: '0, yaw_out: '0};

      hs_ctl.wr_en         = 1'b0;
      hs_ctl.wr_addr       = height_addr(didx_ff, hidx_ff);
      hs_ctl.wr_data.lo    = req_ff.height_low;
      hs_ctl.wr_data.hi    = req_ff.height_high;
      hs_ctl.wr_data.pitch = req_ff.pitch_in;
      hs_ctl.wr_data.yaw   = req_ff.yaw_in;
      hs_ctl.rd_addr       = height_addr(didx_ff, hidx_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               didx_in  = '0;
               state_in = S_DSCAN;
            end
         end
         S_DSCAN: begin
            if (!dist_valid_ff[didx_ff]) begin
               finish = 1'b1;
               if (req_ff.mode == MODE_INSERT) begin
                  dist_valid_in[didx_ff]     = 1'b1;
                  dist_bounds_in[didx_ff].lo = req_ff.dist_low;
                  dist_bounds_in[didx_ff].hi = req_ff.dist_high;
                  height_count_in[didx_ff]   = HCNT_W'(1);
                  hs_ctl.wr_en               = 1'b1;
                  hs_ctl.wr_addr             = height_addr(didx_ff, '0);
               end
            end else if (cmp_hit) begin
               hidx_in  = '0;
               hcnt_in  = height_count_ff[didx_ff];
               state_in = S_HREAD;
            end else if (didx_ff == DIDX_W'(DIST_ENTRIES - 1)) begin
               finish = 1'b1;
               if (req_ff.mode == MODE_INSERT) begin
                  result.status = ST_FULL;
               end
            end else begin
               didx_in = didx_ff + 1'b1;
            end
         end
         S_HREAD: begin
            if (hidx_ff == hcnt_ff) begin
               finish = 1'b1;
               if (req_ff.mode == MODE_INSERT) begin
                  if (hcnt_ff >= HCNT_W'(HEIGHT_ENTRIES)) begin
                     result.status = ST_FULL;
                  end else begin
                     hs_ctl.wr_en             = 1'b1;
                     height_count_in[didx_ff] = hcnt_ff + 1'b1;
                  end
               end
            end else begin
               state_in = S_HCMP;
            end
         end
         S_HCMP: begin
            if (cmp_hit) begin
               finish = 1'b1;
               if (req_ff.mode == MODE_INSERT) begin
                  result.status = ST_OVERLAP;
               end else begin
                  result.found     = 1'b1;
                  result.pitch_out = hs_rd_data.pitch;
                  result.yaw_out   = hs_rd_data.yaw;
               end
            end else begin
               hidx_in  = hidx_ff + 1'b1;
               state_in = S_HREAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         state_in = S_IDLE;
      end
      rsp_strobe_in = finish;
      rsp_in        = finish ? result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < DIST_ENTRIES; i++) begin
            dist_valid_ff[i]   <= 1'b0;
            height_count_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         dist_valid_ff   <= dist_valid_in;
         height_count_ff <= height_count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      didx_ff        <= didx_in;
      hidx_ff        <= hidx_in;
      hcnt_ff        <= hcnt_in;
      rsp_ff         <= rsp_in;
      dist_bounds_ff <= dist_bounds_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== rtl/tlot_cmp.sv =====
// ----------------------------------------------------------------------------
// Two-level interval offset table: band compare unit
// Shared inclusive overlap test of two signed bands, used for both the distance scan and the height compare.
// ----------------------------------------------------------------------------
module tlot_cmp (
   input  logic signed [tlot_pkg::CMP_W-1:0] a_lo,
   input  logic signed [tlot_pkg::CMP_W-1:0] a_hi,
   input  logic signed [tlot_pkg::CMP_W-1:0] b_lo,
   input  logic signed [tlot_pkg::CMP_W-1:0] b_hi,
   output logic                              overlap
);
   import tlot_pkg::*;

   assign overlap = (a_lo <= b_hi) && (b_lo <= a_hi);

endmodule

// ===== rtl/tlot_hstore.sv =====
// ----------------------------------------------------------------------------
// Two-level interval offset table: height store
// One write port and one registered read port over all height entries.
// ----------------------------------------------------------------------------
module tlot_hstore (
   input  logic                       clock,
   input  tlot_pkg::hstore_ctl_type   ctl,
   output tlot_pkg::height_entry_type rd_data
);
   import tlot_pkg::*;

   height_entry_type mem [HSTORE_DEPTH];
   height_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tlot_checker.sv =====
// ----------------------------------------------------------------------------
// Two-level interval offset table: port checker
// Watches the top-level ports for request and result ordering and for
// consistent result fields.
// ----------------------------------------------------------------------------
`include "two_level_interval_offset_table_top_defines.svh"

module tlot_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input tlot_pkg::req_type req_item,
   input logic              rsp_strobe,
   input tlot_pkg::rsp_type rsp_item
);
   import tlot_pkg::*;

   logic unused_req;
   assign unused_req = ^req_item;

   `TLOT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "request not taken")
   `TLOT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_strobe, !rsp_strobe, "strobe repeated")
   `TLOT_ASSERT_SAME(a_end_gives_result, clock, reset, $fell(busy), rsp_strobe, "no result")
   `TLOT_ASSERT_SAME(a_result_at_end, clock, reset, rsp_strobe, $fell(busy), "stray result")
   `TLOT_ASSERT_SAME(a_miss_zero, clock, reset, rsp_strobe && !rsp_item.found,
                     rsp_item.pitch_out == 16'sd0 && rsp_item.yaw_out == 16'sd0,
                     "offsets without match")

endmodule

bind two_level_interval_offset_table_top tlot_checker u_tlot_checker (.*);
